// File: design/can_packet_reassembler_core_assert.svh
// Assertion macros for the packet reassembler; empty under synthesis.
`ifndef CAN_PACKET_REASSEMBLER_CORE_ASSERT_SVH
`define CAN_PACKET_REASSEMBLER_CORE_ASSERT_SVH

`ifndef SYNTHESIS

`define CPR_ASSERT(lbl, expr) \
   lbl: assert property (@(posedge clock) disable iff (reset) (expr)) \
      else $error("cpr assertion failed");

`define CPR_ASSERT_NEXT(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("cpr assertion failed");

`else

`define CPR_ASSERT(lbl, expr)

`define CPR_ASSERT_NEXT(lbl, ante, cons)

`endif

`endif

// File: design/cpr_pkg.sv
package cpr_pkg;

   localparam int FRAMES_PER_PACKET = 7;
   localparam int SLOT_W     = (FRAMES_PER_PACKET > 1) ? $clog2(FRAMES_PER_PACKET) : 1;
   localparam int WORD_W     = 64;
   localparam int BYTE_W     = 8;
   localparam int IDX_W      = 3;
   localparam int CSR_ADDR_W = 2;
   localparam int RSP_DATA_W = ((IDX_W + WORD_W + 7) / 8) * 8;
   localparam int PAD_W      = RSP_DATA_W - IDX_W - WORD_W;

   localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(FRAMES_PER_PACKET - 1);

   localparam logic [BYTE_W-1:0] START_BYTE_RST    = 8'hFC;
   localparam logic [BYTE_W-1:0] END_MARKER_RST    = 8'hFD;
   localparam logic [BYTE_W-1:0] TYPE_BYTE_ONE_RST = 8'h41;
   localparam logic [BYTE_W-1:0] TYPE_BYTE_TWO_RST = 8'h30;

   typedef enum logic [CSR_ADDR_W-1:0] {
      CSR_START_BYTE    = 2'd0,
      CSR_END_MARKER    = 2'd1,
      CSR_TYPE_BYTE_ONE = 2'd2,
      CSR_TYPE_BYTE_TWO = 2'd3
   } csr_index_type;

   typedef enum logic [1:0] {
      ST_IDLE  = 2'b01,
      ST_DRAIN = 2'b10
   } state_type;

   typedef struct packed {
      logic              en;
      logic [SLOT_W-1:0] addr;
      logic [WORD_W-1:0] data;
   } store_wr_type;

   typedef struct packed {
      logic              en;
      logic [SLOT_W-1:0] addr;
   } store_rd_type;

endpackage

// File: design/cpr_frame_store.sv
module cpr_frame_store (
   input  logic                      clock,
   input  cpr_pkg::store_wr_type     wr,
   input  cpr_pkg::store_rd_type     rd,
   output logic [cpr_pkg::WORD_W-1:0] rd_data
);

   logic [cpr_pkg::WORD_W-1:0] frame_mem_ff [cpr_pkg::FRAMES_PER_PACKET];
   logic [cpr_pkg::WORD_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr.en) begin
         frame_mem_ff[wr.addr] <= wr.data;
      end
   end

   // read data holds until the next read so a stalled word is not lost
   always_ff @(posedge clock) begin
      if (rd.en) begin
         rd_data_ff <= frame_mem_ff[rd.addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// File: design/can_packet_reassembler_core.sv
// CAN packet reassembler.
// req_*: one 8-byte CAN payload per transaction, byte 0 in tdata[7:0].
// rsp_*: one stored word per transaction; tdata holds word_index in [2:0] and
//   the 64-bit word in [66:3]; tlast flags the final word of a packet.
// csr_*: write-only register port, index 0 start byte, 1 end marker,
//   2 and 3 the two type bytes. Write only while no packet is being emitted.
// A payload whose byte 0 is the start byte, following a payload whose byte 7
// was the end marker, opens a packet. Seven payloads fill the frame store;
// if the header type bytes matched, the seven words are then read out of the
// store in order, otherwise the packet is dropped.
// Throughput: one payload per cycle, except that completing an accepted packet
// holds req_tready low while the store's single read port issues one read per
// cycle unless the output stalls. After the closing payload, the first word passes
// the state, store read and output registers, then one word per cycle while rsp_tready stays high.
// A stalled receiver holds the output register and the store's read data,
// which stalls the read-out and with it the input.
// Reset: the CSR registers return to their defaults, no packet in progress, no output.
// The store needs no clearing pass; every word read was written in the packet.
`include "can_packet_reassembler_core_assert.svh"

module can_packet_reassembler_core (
   input  logic                               clock,
   input  logic                               reset,
   // frame_data[63:0]
   input  logic [cpr_pkg::WORD_W-1:0]         req_tdata,
   input  logic                               req_tvalid,
   output logic                               req_tready,
   // word_index[2:0], packet_word[66:3], zero fill
   output logic [cpr_pkg::RSP_DATA_W-1:0]     rsp_tdata,
   output logic                               rsp_tlast,
   output logic                               rsp_tvalid,
   input  logic                               rsp_tready,
   input  logic                               csr_we,
   input  logic [cpr_pkg::CSR_ADDR_W-1:0]     csr_addr,
   input  logic [cpr_pkg::BYTE_W-1:0]         csr_wdata
);

   localparam int SW = cpr_pkg::SLOT_W;

   logic [cpr_pkg::BYTE_W-1:0] start_byte_ff, end_marker_ff, type_one_ff, type_two_ff;
   logic [cpr_pkg::BYTE_W-1:0] prev_byte_ff, prev_byte_in;
   logic [SW-1:0]              slot_ff, slot_in;
   logic                       accept_ff, accept_in;
   cpr_pkg::state_type         st_ff, st_in;
   logic [SW-1:0]              rd_idx_ff, rd_idx_in;
   logic                       pend_ff, pend_in;
   logic [SW-1:0]              pend_idx_ff, pend_idx_in;
   logic                       rsp_valid_ff, rsp_valid_in;
   logic [cpr_pkg::IDX_W-1:0]  rsp_idx_ff, rsp_idx_in;
   logic [cpr_pkg::WORD_W-1:0] rsp_word_ff, rsp_word_in;
   logic                       rsp_last_ff, rsp_last_in;

   logic                       req_acc, header, type_ok, active, acc_cur, load_out;
   logic [SW-1:0]              slot_cur;
   logic [cpr_pkg::WORD_W-1:0] rd_data;
   cpr_pkg::store_wr_type      wr;
   cpr_pkg::store_rd_type      rd;

   cpr_frame_store u_store (
      .clock   (clock),
      .wr      (wr),
      .rd      (rd),
      .rd_data (rd_data)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         start_byte_ff <= cpr_pkg::START_BYTE_RST;
         end_marker_ff <= cpr_pkg::END_MARKER_RST;
         type_one_ff   <= cpr_pkg::TYPE_BYTE_ONE_RST;
         type_two_ff   <= cpr_pkg::TYPE_BYTE_TWO_RST;
      end else if (csr_we) begin
         unique case (cpr_pkg::csr_index_type'(csr_addr))
            cpr_pkg::CSR_START_BYTE:    start_byte_ff <= csr_wdata;
            cpr_pkg::CSR_END_MARKER:    end_marker_ff <= csr_wdata;
            cpr_pkg::CSR_TYPE_BYTE_ONE: type_one_ff   <= csr_wdata;
            cpr_pkg::CSR_TYPE_BYTE_TWO: type_two_ff   <= csr_wdata;
         endcase
      end
   end

   assign req_tready = (st_ff == cpr_pkg::ST_IDLE);
   assign req_acc    = req_tvalid && req_tready;

   // header test uses byte 7 of the payload before this one
   assign header   = (req_tdata[7:0] == start_byte_ff) && (prev_byte_ff == end_marker_ff);
   assign type_ok  = (req_tdata[15:8] == type_one_ff) && (req_tdata[23:16] == type_two_ff);
   assign active   = header || (slot_ff != '0);
   assign slot_cur = header ? '0 : slot_ff;
   assign acc_cur  = header ? type_ok : accept_ff;

   assign load_out = pend_ff && (!rsp_valid_ff || rsp_tready);

   always_comb begin
      wr.en        = req_acc && active;
      wr.addr      = slot_cur;
      wr.data      = req_tdata;
      rd.en        = 1'b0;
      rd.addr      = rd_idx_ff;
      st_in        = st_ff;
      prev_byte_in = prev_byte_ff;
      slot_in      = slot_ff;
      accept_in    = accept_ff;
      rd_idx_in    = rd_idx_ff;
      pend_idx_in  = pend_idx_ff;

      unique case (st_ff)
         cpr_pkg::ST_IDLE: begin
            if (req_acc) begin
               prev_byte_in = req_tdata[63:56];
               if (active) begin
                  if (slot_cur == cpr_pkg::LAST_SLOT) begin
                     slot_in   = '0;
                     accept_in = 1'b0;
                     if (acc_cur) begin
                        st_in = cpr_pkg::ST_DRAIN;
                     end
                  end else begin
                     slot_in   = slot_cur + SW'(1);
                     accept_in = acc_cur;
                  end
               end
            end
         end
         cpr_pkg::ST_DRAIN: begin
            rd.en = !pend_ff || load_out;
            if (rd.en) begin
               pend_idx_in = rd_idx_ff;
               if (rd_idx_ff == cpr_pkg::LAST_SLOT) begin
                  rd_idx_in = '0;
                  st_in     = cpr_pkg::ST_IDLE;
               end else begin
                  rd_idx_in = rd_idx_ff + SW'(1);
               end
            end
         end
         default: begin
            st_in = cpr_pkg::ST_IDLE;
         end
      endcase
   end

   always_comb begin
      pend_in      = rd.en ? 1'b1 : (load_out ? 1'b0 : pend_ff);
      rsp_valid_in = rsp_valid_ff;
      rsp_idx_in   = rsp_idx_ff;
      rsp_word_in  = rsp_word_ff;
      rsp_last_in  = rsp_last_ff;
      if (load_out) begin
         rsp_valid_in = 1'b1;
         rsp_idx_in   = cpr_pkg::IDX_W'(pend_idx_ff);
         rsp_word_in  = rd_data;
         rsp_last_in  = (pend_idx_ff == cpr_pkg::LAST_SLOT);
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff        <= cpr_pkg::ST_IDLE;
         prev_byte_ff <= '0;
         slot_ff      <= '0;
         accept_ff    <= 1'b0;
         rd_idx_ff    <= '0;
         pend_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         st_ff        <= st_in;
         prev_byte_ff <= prev_byte_in;
         slot_ff      <= slot_in;
         accept_ff    <= accept_in;
         rd_idx_ff    <= rd_idx_in;
         pend_ff      <= pend_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      pend_idx_ff <= pend_idx_in;
      rsp_idx_ff  <= rsp_idx_in;
      rsp_word_ff <= rsp_word_in;
      rsp_last_ff <= rsp_last_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tlast  = rsp_last_ff;
   assign rsp_tdata  = {{cpr_pkg::PAD_W{1'b0}}, rsp_word_ff, rsp_idx_ff};

   `CPR_ASSERT(a_no_rd_wr_overlap, !(rd.en && wr.en))
   `CPR_ASSERT(a_slot_in_range, slot_ff <= cpr_pkg::LAST_SLOT)
   `CPR_ASSERT(a_last_index, !(rsp_valid_ff && rsp_last_ff) || (rsp_idx_ff == cpr_pkg::IDX_W'(cpr_pkg::LAST_SLOT)))
   `CPR_ASSERT_NEXT(a_pend_held, pend_ff && rsp_valid_ff && !rsp_tready, pend_ff && $stable(rd_data))

endmodule
